@@ hw/rtl/rmp_pkg.sv @@
`timescale 1ns / 1ps
package rmp_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int CMD_W  = 3;
  localparam int CH_W   = 3;
  localparam int RATE_W = 18;
  localparam int NCH_W  = 4;
  localparam int VAL_W  = 32;
  localparam int DUR_W  = 20;
  localparam int ACC_W  = 48;
  localparam int CNT_W  = 22;
  localparam int PROD_W = DUR_W + RATE_W;
  localparam int DIVN_W = ACC_W + 1;
  localparam int FRAC_X = ACC_W - VAL_W;
  localparam int ADDR_W = 4;

  localparam logic [RATE_W-1:0] RATE_DEFAULT = RATE_W'(48000);
  localparam logic [NCH_W-1:0]  NCH_RESET    = NCH_W'(1);
  localparam logic [VAL_W-1:0]  INIT_RESET   = '0;
  localparam logic [PROD_W-1:0] ROUND_HALF   = PROD_W'(32768);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK      = 3'd0,
    CMD_SET_CH    = 3'd1,
    CMD_SET_ALL   = 3'd2,
    CMD_RESET_ALL = 3'd3,
    CMD_READ      = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    REG_SAMPLE_RATE = 2'd0,
    REG_NUM_CH      = 2'd1,
    REG_INIT_VALUE  = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_SETALL,
    ST_RD,
    ST_EVAL,
    ST_APPLY,
    ST_DIV,
    ST_STEP,
    ST_RDOUT
  } state_e;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [NCH_W-1:0]  nch;
    logic              init_load;
    logic [VAL_W-1:0]  init_value;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] num;
    logic [CNT_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVN_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic [VAL_W-1:0] tgt;
    logic [ACC_W-1:0] step;
    logic [CNT_W-1:0] left;
  } main_t;

  typedef struct packed {
    logic             flag;
    logic [VAL_W-1:0] ptgt;
    logic [DUR_W-1:0] pdur;
  } pend_t;

  function automatic logic [ACC_W-1:0] widen(input logic [VAL_W-1:0] v);
    return {v, {FRAC_X{1'b0}}};
  endfunction

endpackage

@@ hw/rtl/multichannel_linear_ramp_smoother_unit.sv @@
`timescale 1ns / 1ps
// Per-channel linear ramp of Q8.24 values, state held in two memories with
// registered reads (ramp state and pending update) and worked one channel at a
// time. A tick walks the active channels: each channel is read, evaluated and
// stepped; one with a pending update also passes the apply state and, when its
// sample count is not zero, the divide state, where the 49-step shared divider
// forms the step. Each result waits in the output register until taken, which
// stalls the walk. Set-all and reset-all sweep the active channels at one entry
// per cycle; set-channel writes its pending update from idle, a read of an
// active channel is read and evaluated first, and a read out of range goes
// straight to output. After reset and after each write of the start-value
// register a pass loads every entry, and no input transfer is taken during it.
module multichannel_linear_ramp_smoother_unit
  import rmp_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration, apb style
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  // command transfers
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [CH_W-1:0]   in_channel,
  input  logic [VAL_W-1:0]  in_target_value,
  input  logic [DUR_W-1:0]  in_duration,
  // result transfers
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CH_W-1:0]   out_channel,
  output logic [VAL_W-1:0]  out_value,
  output logic              out_smoothing,
  output logic              out_last
);

  logic [RATE_W-1:0] rate_r;
  logic [NCH_W-1:0]  nch_r;
  logic [VAL_W-1:0]  init_r;
  logic              wr;
  reg_e              ridx;
  cfg_t              cfg;

  assign cfg_pready = 1'b1;
  assign wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign ridx = reg_e'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_DEFAULT;
      nch_r  <= NCH_RESET;
      init_r <= INIT_RESET;
    end else if (wr) begin
      case (ridx)
        REG_SAMPLE_RATE: rate_r <= cfg_pwdata[RATE_W-1:0];
        REG_NUM_CH:      nch_r  <= cfg_pwdata[NCH_W-1:0];
        REG_INIT_VALUE:  init_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_SAMPLE_RATE: cfg_prdata = 32'(rate_r);
      REG_NUM_CH:      cfg_prdata = 32'(nch_r);
      REG_INIT_VALUE:  cfg_prdata = init_r;
      default:         cfg_prdata = '0;
    endcase
  end

  // a zero rate means the default rate; a start-value write reloads all channels
  always_comb begin
    cfg.rate       = (rate_r == '0) ? RATE_DEFAULT : rate_r;
    cfg.nch        = nch_r;
    cfg.init_load  = wr && (ridx == REG_INIT_VALUE);
    cfg.init_value = cfg_pwdata;
  end

  rmp_ctrl #(
    .CHANNELS(CHANNELS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_channel     (in_channel),
    .in_target_value(in_target_value),
    .in_duration    (in_duration),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_channel    (out_channel),
    .out_value      (out_value),
    .out_smoothing  (out_smoothing),
    .out_last       (out_last)
  );

endmodule

@@ hw/rtl/rmp_div.sv @@
`timescale 1ns / 1ps
module rmp_div
  import rmp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int IT_W = $clog2(DIVN_W + 1);

  logic [DIVN_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  den_r;
  logic [IT_W-1:0]   it_r, it_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W:0]    shifted;
  logic [CNT_W+1:0]  sub;
  logic              ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted  = {rem_r, quo_r[DIVN_W-1]};
    sub      = {1'b0, shifted} - {2'b0, den_r};
    ge       = !sub[CNT_W+1];
    rem_nxt  = ge ? sub[CNT_W-1:0] : shifted[CNT_W-1:0];
    quo_nxt  = {quo_r[DIVN_W-2:0], ge};
    it_nxt   = it_r - IT_W'(1);
    busy_nxt = busy_r && (it_r != IT_W'(1));
    done_nxt = busy_r && (it_r == IT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      it_r   <= IT_W'(DIVN_W);
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (busy_r) it_r <= it_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

@@ hw/rtl/rmp_ctrl.sv @@
`timescale 1ns / 1ps
module rmp_ctrl
  import rmp_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [CH_W-1:0]   in_channel,
  input  logic [VAL_W-1:0]  in_target_value,
  input  logic [DUR_W-1:0]  in_duration,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CH_W-1:0]   out_channel,
  output logic [VAL_W-1:0]  out_value,
  output logic              out_smoothing,
  output logic              out_last
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NW = $clog2(CHANNELS + 1);

  // per-channel state memories
  main_t main_mem [CHANNELS];
  pend_t pend_mem [CHANNELS];
  main_t main_rd_r;
  pend_t pend_rd_r;

  state_e state_r, state_nxt;
  logic [CW-1:0]    idx_r;
  logic [NW-1:0]    lim_r;
  logic [VAL_W-1:0] val_r;
  logic [DUR_W-1:0] dur_r;
  logic [CH_W-1:0]  ch_r;
  logic             rd_read_r;
  logic             rd_zero_r;

  logic [ACC_W-1:0]  acc_w_r, step_w_r;
  logic [VAL_W-1:0]  tgt_w_r;
  logic [CNT_W-1:0]  left_w_r;
  logic [PROD_W-1:0] prod_r;
  logic              neg_r;

  logic              out_valid_r;
  logic [CH_W-1:0]   out_ch_r;
  logic [VAL_W-1:0]  out_val_r;
  logic              out_sm_r, out_last_r;

  logic [NW-1:0]     n_act;
  logic              in_acc, ch_ok, out_free, at_end;
  logic              main_we, pend_we, rd_en, out_load;
  logic [CW-1:0]     main_wa, pend_wa;
  main_t             main_wd;
  pend_t             pend_wd;
  logic [PROD_W-1:0] prod_rnd;
  logic [CNT_W-1:0]  cnt;
  logic [DIVN_W-1:0] diff, mag;
  logic [DIVN_W:0]   sq;
  logic [ACC_W-1:0]  step_sat;
  logic [ACC_W-1:0]  acc_new;
  logic [CNT_W-1:0]  left_dec, left_new;
  div_req_t          dreq;
  div_rsp_t          drsp;

  rmp_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  always_comb begin
    n_act    = (32'(cfg.nch) > 32'(CHANNELS)) ? NW'(CHANNELS) : NW'(cfg.nch);
    in_acc   = in_valid && in_ready;
    ch_ok    = 32'(in_channel) < 32'(n_act);
    out_free = !out_valid_r || out_ready;
    at_end   = (NW'(idx_r) + NW'(1)) == lim_r;

    prod_rnd = prod_r + ROUND_HALF;
    cnt      = prod_rnd[PROD_W-1:16];
    diff     = {tgt_w_r[VAL_W-1], widen(tgt_w_r)} - {acc_w_r[ACC_W-1], acc_w_r};
    mag      = diff[DIVN_W-1] ? -diff : diff;

    sq = neg_r ? -{1'b0, drsp.quo} : {1'b0, drsp.quo};
    if ($signed(sq) > $signed({{(DIVN_W-ACC_W+1){1'b0}}, {1'b0, {(ACC_W-1){1'b1}}}}))
      step_sat = {1'b0, {(ACC_W-1){1'b1}}};
    else if ($signed(sq) < $signed({{(DIVN_W-ACC_W+1){1'b1}}, {1'b1, {(ACC_W-1){1'b0}}}}))
      step_sat = {1'b1, {(ACC_W-1){1'b0}}};
    else
      step_sat = sq[ACC_W-1:0];

    left_dec = left_w_r - CNT_W'(1);
    if (left_w_r != '0) begin
      left_new = left_dec;
      acc_new  = (left_dec == '0) ? widen(tgt_w_r) : acc_w_r + step_w_r;
    end else begin
      left_new = left_w_r;
      acc_new  = acc_w_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    if (cfg.init_load) begin
      state_nxt = ST_SWEEP;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (cmd_e'(in_cmd))
              CMD_TICK:      if (n_act != '0) state_nxt = ST_RD;
              CMD_SET_ALL:   if (n_act != '0) state_nxt = ST_SETALL;
              CMD_RESET_ALL: if (n_act != '0) state_nxt = ST_SWEEP;
              CMD_READ:      state_nxt = ch_ok ? ST_RD : ST_RDOUT;
              default:       state_nxt = ST_IDLE;
            endcase
          end
        end
        ST_SWEEP, ST_SETALL: if (at_end) state_nxt = ST_IDLE;
        ST_RD:   state_nxt = ST_EVAL;
        ST_EVAL: begin
          if (rd_read_r)           state_nxt = ST_RDOUT;
          else if (pend_rd_r.flag) state_nxt = ST_APPLY;
          else                     state_nxt = ST_STEP;
        end
        ST_APPLY: state_nxt = (cnt == '0) ? ST_STEP : ST_DIV;
        ST_DIV:   if (drsp.done) state_nxt = ST_STEP;
        ST_STEP:  if (out_free) state_nxt = at_end ? ST_IDLE : ST_RD;
        ST_RDOUT: if (out_free) state_nxt = ST_IDLE;
        default:  state_nxt = ST_IDLE;
      endcase
    end
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    main_we  = 1'b0;
    pend_we  = 1'b0;
    rd_en    = (state_r == ST_RD);
    out_load = 1'b0;
    main_wa  = idx_r;
    pend_wa  = idx_r;
    main_wd  = '{acc: widen(val_r), tgt: val_r, step: '0, left: '0};
    pend_wd  = '{flag: 1'b0, ptgt: val_r, pdur: dur_r};
    dreq     = '{start: 1'b0, num: mag, den: cnt};
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (cmd_e'(in_cmd) == CMD_SET_CH) && ch_ok) begin
          pend_we = 1'b1;
          pend_wa = CW'(in_channel);
          pend_wd = '{flag: 1'b1, ptgt: in_target_value, pdur: in_duration};
        end
      end
      ST_SWEEP: begin
        main_we = 1'b1;
        pend_we = 1'b1;
      end
      ST_SETALL: begin
        pend_we      = 1'b1;
        pend_wd.flag = 1'b1;
      end
      ST_APPLY: dreq.start = (cnt != '0);
      ST_STEP: begin
        if (out_free) begin
          out_load = 1'b1;
          main_we  = 1'b1;
          pend_we  = 1'b1;
          main_wd  = '{acc: acc_new, tgt: tgt_w_r, step: step_w_r, left: left_new};
        end
      end
      ST_RDOUT: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (main_we) main_mem[main_wa] <= main_wd;
    if (pend_we) pend_mem[pend_wa] <= pend_wd;
    if (rd_en) begin
      main_rd_r <= main_mem[idx_r];
      pend_rd_r <= pend_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      idx_r       <= '0;
      lim_r       <= NW'(CHANNELS);
      val_r       <= INIT_RESET;
      dur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg.init_load) begin
        idx_r <= '0;
        lim_r <= NW'(CHANNELS);
        val_r <= cfg.init_value;
      end else if (in_acc) begin
        idx_r <= (cmd_e'(in_cmd) == CMD_READ) ? CW'(in_channel) : '0;
        lim_r <= n_act;
        val_r <= in_target_value;
        dur_r <= in_duration;
      end else if (((state_r == ST_SWEEP) || (state_r == ST_SETALL) ||
                    ((state_r == ST_STEP) && out_free)) && !at_end) begin
        idx_r <= idx_r + CW'(1);
      end
    end
  end

  // working copy of one channel
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r      <= in_channel;
      rd_read_r <= (cmd_e'(in_cmd) == CMD_READ);
      rd_zero_r <= !ch_ok;
    end
    unique case (state_r)
      ST_EVAL: begin
        acc_w_r  <= main_rd_r.acc;
        tgt_w_r  <= main_rd_r.tgt;
        step_w_r <= main_rd_r.step;
        left_w_r <= main_rd_r.left;
        prod_r   <= PROD_W'(pend_rd_r.pdur) * PROD_W'(cfg.rate);
        if (pend_rd_r.flag) tgt_w_r <= pend_rd_r.ptgt;
      end
      ST_APPLY: begin
        left_w_r <= cnt;
        neg_r    <= diff[DIVN_W-1];
        if (cnt == '0) begin
          acc_w_r  <= widen(tgt_w_r);
          step_w_r <= '0;
        end
      end
      ST_DIV: if (drsp.done) step_w_r <= step_sat;
      default: ;
    endcase
    if (out_load) begin
      if (state_r == ST_RDOUT) begin
        out_ch_r   <= ch_r;
        out_val_r  <= rd_zero_r ? '0 : acc_w_r[ACC_W-1:FRAC_X];
        out_sm_r   <= !rd_zero_r && (left_w_r != '0);
        out_last_r <= 1'b1;
      end else begin
        out_ch_r   <= CH_W'(idx_r);
        out_val_r  <= acc_new[ACC_W-1:FRAC_X];
        out_sm_r   <= (left_new != '0);
        out_last_r <= at_end;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_channel   = out_ch_r;
  assign out_value     = out_val_r;
  assign out_smoothing = out_sm_r;
  assign out_last      = out_last_r;

`ifndef SYNTH
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> (state_r == ST_DIV))
    else $error("divider finished outside divide state");
  a_ready_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !main_we || (state_r == ST_IDLE && !main_we))
    else $error("state memory written while taking input");
  a_load_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("loaded result not presented");
  a_div_start_apply: assert property (@(posedge clk) disable iff (!rst_n)
    dreq.start |=> (state_r == ST_DIV))
    else $error("divide started without waiting for it");
`endif

endmodule
